@@ design/savitzky_golay_fir_filter_core_macros.svh @@
// Assertion helpers shared by the filter modules.
// Both sample on the rising edge of clk and are off while rst_n is low.
`ifndef SAVITZKY_GOLAY_FIR_FILTER_CORE_MACROS_SVH
`define SAVITZKY_GOLAY_FIR_FILTER_CORE_MACROS_SVH

`define SGF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define SGF_ASSERT_NEVER(lbl, expr, msg) `SGF_ASSERT(lbl, !(expr), msg)

`endif

@@ design/sgf_pkg.sv @@
package sgf_pkg;

  localparam int COEF_W    = 24;
  localparam int WIN_W     = 3;
  localparam int OUT_W     = 48;
  localparam int NUM_COEF  = 7;
  localparam int CNT_W     = 3;
  localparam int POS_W     = 5;
  localparam int CFG_IDX_W = 4;

  localparam logic [CNT_W-1:0] RES_CAP   = 3'd4;
  localparam logic [2:0]       SEEN_MAX  = 3'd7;
  localparam logic [WIN_W-1:0] WIN_RESET = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_0      = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_6      = 4'd7;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_SHORT   = 2'd1,
    STAT_BAD_WIN = 2'd2
  } sgf_status_t;

  typedef struct packed {
    logic        valid;
    logic        last;
    sgf_status_t status;
  } sgf_ctl_t;

endpackage

@@ design/savitzky_golay_fir_filter_core.sv @@
// Each result is formed in the issue stage and then passes through the registered chain of MAC cells.
// Throughput: one result per cycle while out_tready is high; an item giving several results holds
// in_tready low until its last result issues, so items with at most one result are taken every cycle unless stalled.
// The rate is set by the single issue slot feeding the chain of MAC cells.
// Reset (rst_n low, synchronous): run state and pipeline emptied, taps in use = 5,
// coefficients 0; stored samples are not cleared.
module savitzky_golay_fir_filter_core #(
  parameter int MAX_TAPS    = 7,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // in_tdata: [SAMPLE_BITS-1:0] sample, rest zero
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] in_tdata,
  input  logic                                   in_tlast,
  // out_tdata: [47:0] filtered
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [sgf_pkg::OUT_W-1:0]              out_tdata,
  output logic                                   out_tlast,
  // out_tuser: [1:0] status
  output logic [1:0]                             out_tuser,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [sgf_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [sgf_pkg::COEF_W-1:0]             cfg_data
);

  localparam int PAD_W = SAMPLE_BITS + 2;

  logic [sgf_pkg::WIN_W-1:0]         taps_r;
  logic signed [sgf_pkg::COEF_W-1:0] coef_r   [sgf_pkg::NUM_COEF];
  logic signed [sgf_pkg::COEF_W-1:0] tap_coef [MAX_TAPS];

  sgf_pkg::sgf_ctl_t                 lnk_ctl   [MAX_TAPS+1];
  logic [sgf_pkg::OUT_W-1:0]         lnk_sum   [MAX_TAPS+1];
  logic [MAX_TAPS-1:0][PAD_W-1:0]    lnk_pads  [MAX_TAPS+1];
  logic                              lnk_ready [MAX_TAPS+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taps_r <= sgf_pkg::WIN_RESET;
      for (int i = 0; i < sgf_pkg::NUM_COEF; i++) begin
        coef_r[i] <= '0;
      end
    end else if (cfg_valid) begin
      unique case (cfg_index) inside
        sgf_pkg::CFG_WINDOW_SIZE: begin
          taps_r <= cfg_data[sgf_pkg::WIN_W-1:0];
        end
        [sgf_pkg::CFG_COEF_0:sgf_pkg::CFG_COEF_6]: begin
          coef_r[3'(cfg_index - sgf_pkg::CFG_COEF_0)] <= $signed(cfg_data);
        end
        default: begin
        end
      endcase
    end
  end

  // oldest tap takes coef_(w-1), newest coef_0; unused taps weigh nothing
  always_comb begin
    for (int j = 0; j < MAX_TAPS; j++) begin
      if (3'(j) < taps_r) begin
        tap_coef[j] = coef_r[3'(taps_r - 3'(j) - 3'd1)];
      end else begin
        tap_coef[j] = '0;
      end
    end
  end

  sgf_issue #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_issue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sample    ($signed(in_tdata[SAMPLE_BITS-1:0])),
    .in_tlast  (in_tlast),
    .win_size  (taps_r),
    .dn_ctl    (lnk_ctl[0]),
    .dn_pads   (lnk_pads[0]),
    .dn_ready  (lnk_ready[0])
  );

  assign lnk_sum[0]          = '0;
  assign lnk_ready[MAX_TAPS] = out_tready;

  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
    sgf_cell #(
      .MAX_TAPS    (MAX_TAPS),
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_ctl   (lnk_ctl[k]),
      .up_sum   (lnk_sum[k]),
      .up_pads  (lnk_pads[k]),
      .up_ready (lnk_ready[k]),
      .coef     (tap_coef[k]),
      .dn_ctl   (lnk_ctl[k+1]),
      .dn_sum   (lnk_sum[k+1]),
      .dn_pads  (lnk_pads[k+1]),
      .dn_ready (lnk_ready[k+1])
    );
  end

  assign out_tvalid = lnk_ctl[MAX_TAPS].valid;
  assign out_tdata  = lnk_sum[MAX_TAPS];
  assign out_tlast  = lnk_ctl[MAX_TAPS].last;
  assign out_tuser  = lnk_ctl[MAX_TAPS].status;

`include "savitzky_golay_fir_filter_core_macros.svh"

  `SGF_ASSERT(a_err_out, (out_tvalid && out_tuser != 2'(sgf_pkg::STAT_OK)) |-> (out_tlast && out_tdata == '0), "error result not zero or not last")

endmodule

@@ design/sgf_cell.sv @@
module sgf_cell #(
  parameter int MAX_TAPS    = 7,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  sgf_pkg::sgf_ctl_t                       up_ctl,
  input  logic [sgf_pkg::OUT_W-1:0]               up_sum,
  input  logic [MAX_TAPS-1:0][SAMPLE_BITS+1:0]    up_pads,
  output logic                                    up_ready,
  input  logic signed [sgf_pkg::COEF_W-1:0]       coef,
  output sgf_pkg::sgf_ctl_t                       dn_ctl,
  output logic [sgf_pkg::OUT_W-1:0]               dn_sum,
  output logic [MAX_TAPS-1:0][SAMPLE_BITS+1:0]    dn_pads,
  input  logic                                    dn_ready
);

  localparam int PAD_W  = SAMPLE_BITS + 2;
  localparam int PROD_W = PAD_W + sgf_pkg::COEF_W;

  sgf_pkg::sgf_ctl_t                ctl_r;
  logic [sgf_pkg::OUT_W-1:0]        sum_r;
  logic [MAX_TAPS-1:0][PAD_W-1:0]   pads_r;
  logic [MAX_TAPS-1:0][PAD_W-1:0]   pads_nxt;
  logic [sgf_pkg::OUT_W-1:0]        sum_nxt;
  logic signed [PROD_W-1:0]         prod;
  logic signed [63:0]               prod_ext;
  logic                             load;

  assign load     = !ctl_r.valid || dn_ready;
  assign up_ready = load;

  // this cell always weights the head tap; the rest move down one place
  assign prod     = $signed(up_pads[0]) * coef;
  assign prod_ext = 64'(prod);
  assign sum_nxt  = up_sum + prod_ext[sgf_pkg::OUT_W-1:0];

  always_comb begin
    for (int i = 0; i < MAX_TAPS - 1; i++) begin
      pads_nxt[i] = up_pads[i + 1];
    end
    pads_nxt[MAX_TAPS-1] = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (load) begin
      ctl_r <= up_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sum_r  <= sum_nxt;
      pads_r <= pads_nxt;
    end
  end

  assign dn_ctl  = ctl_r;
  assign dn_sum  = sum_r;
  assign dn_pads = pads_r;

`include "savitzky_golay_fir_filter_core_macros.svh"

  `SGF_ASSERT(a_cell_hold, (ctl_r.valid && !dn_ready) |=> (ctl_r.valid && $stable(sum_r)), "cell item changed while stalled")

endmodule

@@ design/sgf_issue.sv @@
module sgf_issue #(
  parameter int MAX_TAPS    = 7,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  input  logic signed [SAMPLE_BITS-1:0]           sample,
  input  logic                                    in_tlast,
  input  logic [sgf_pkg::WIN_W-1:0]               win_size,
  output sgf_pkg::sgf_ctl_t                       dn_ctl,
  output logic [MAX_TAPS-1:0][SAMPLE_BITS+1:0]    dn_pads,
  input  logic                                    dn_ready
);

  localparam int PAD_W = SAMPLE_BITS + 2;
  localparam int IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam logic [sgf_pkg::WIN_W-1:0] MAX_W = sgf_pkg::WIN_W'(MAX_TAPS);

  logic signed [SAMPLE_BITS-1:0]      win_r [MAX_TAPS];
  logic [2:0]                         seen_r;
  logic                               stream_r;
  logic [sgf_pkg::CNT_W-1:0]          cnt_r;
  logic [sgf_pkg::WIN_W-1:0]          t_r;
  logic                               fin_r;
  sgf_pkg::sgf_status_t               err_r;
  sgf_pkg::sgf_ctl_t                  ctl_r;
  logic [MAX_TAPS-1:0][PAD_W-1:0]     pads_r;
  logic [MAX_TAPS-1:0][PAD_W-1:0]     pads_nxt;

  logic                               w_ok;
  logic [sgf_pkg::WIN_W-1:0]          half;
  logic [2:0]                         seen_nxt;
  logic                               in_acc;
  logic                               iss_load;
  logic                               acc_any;
  logic                               acc_stream;
  logic [sgf_pkg::WIN_W-1:0]          acc_first;
  logic [sgf_pkg::WIN_W-1:0]          acc_last;
  logic [sgf_pkg::WIN_W-1:0]          acc_span;
  logic [sgf_pkg::CNT_W-1:0]          acc_cnt;
  sgf_pkg::sgf_status_t               acc_err;

  assign w_ok     = win_size[0] && (win_size <= MAX_W);
  assign half     = win_size >> 1;
  assign seen_nxt = (seen_r == sgf_pkg::SEEN_MAX) ? seen_r : seen_r + 3'd1;
  assign iss_load = !ctl_r.valid || dn_ready;
  assign in_tready = (cnt_r == '0) || ((cnt_r == sgf_pkg::CNT_W'(1)) && iss_load);
  assign in_acc   = in_tvalid && in_tready;

  // results due for the arriving sample: a range of output positions or one error
  always_comb begin
    acc_any    = 1'b0;
    acc_stream = stream_r;
    acc_first  = '0;
    acc_last   = '0;
    acc_err    = sgf_pkg::STAT_OK;
    if (w_ok) begin
      if (!stream_r) begin
        if (seen_nxt >= win_size) begin
          acc_any    = 1'b1;
          acc_stream = 1'b1;
          acc_last   = in_tlast ? win_size - 3'd1 : half;
        end else if (in_tlast) begin
          acc_any = 1'b1;
          acc_err = sgf_pkg::STAT_SHORT;
        end
      end else begin
        acc_any   = 1'b1;
        acc_first = half;
        acc_last  = in_tlast ? win_size - 3'd1 : half;
      end
    end else if (in_tlast) begin
      acc_any = 1'b1;
      acc_err = sgf_pkg::STAT_BAD_WIN;
    end
    if (in_tlast) begin
      acc_stream = 1'b0;
    end
    acc_span = acc_last - acc_first + 3'd1;
    if (!acc_any) begin
      acc_cnt = '0;
    end else if (acc_span > sgf_pkg::RES_CAP) begin
      acc_cnt = sgf_pkg::RES_CAP;
    end else begin
      acc_cnt = acc_span;
    end
  end

  // padded window for output position t_r; ends pad to edge -/+ |mirror - edge|
  always_comb begin
    logic signed [sgf_pkg::POS_W-1:0] q;
    logic signed [sgf_pkg::POS_W-1:0] wl;
    logic signed [sgf_pkg::POS_W-1:0] m;
    logic signed [sgf_pkg::POS_W-1:0] idx;
    logic signed [PAD_W-1:0]          val;
    logic signed [PAD_W-1:0]          edge_v;
    logic signed [PAD_W-1:0]          diff;
    logic signed [PAD_W-1:0]          mag;
    q      = '0;
    m      = '0;
    idx    = '0;
    val    = '0;
    edge_v = '0;
    diff   = '0;
    mag    = '0;
    wl = $signed({2'b00, win_size}) - 5'sd1;
    for (int j = 0; j < MAX_TAPS; j++) begin
      q = $signed({2'b00, t_r} + sgf_pkg::POS_W'(j) - {2'b00, half});
      pads_nxt[j] = '0;
      if (err_r == sgf_pkg::STAT_OK && sgf_pkg::WIN_W'(j) < win_size) begin
        if (q < 0) begin
          m = -q;
        end else if (q > wl) begin
          m = (wl <<< 1) - q;
        end else begin
          m = q;
        end
        idx = wl - m;
        val = PAD_W'(win_r[idx[IDX_W-1:0]]);
        if (q < 0) begin
          edge_v = PAD_W'(win_r[wl[IDX_W-1:0]]);
        end else begin
          edge_v = PAD_W'(win_r[0]);
        end
        diff = val - edge_v;
        mag  = (diff < 0) ? -diff : diff;
        if (q < 0) begin
          pads_nxt[j] = edge_v - mag;
        end else if (q > wl) begin
          pads_nxt[j] = edge_v + mag;
        end else begin
          pads_nxt[j] = val;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r   <= '0;
      stream_r <= 1'b0;
      cnt_r    <= '0;
      ctl_r    <= '0;
    end else begin
      if (iss_load) begin
        ctl_r.valid  <= (cnt_r != '0);
        ctl_r.last   <= fin_r && (cnt_r == sgf_pkg::CNT_W'(1));
        ctl_r.status <= err_r;
      end
      if (in_acc) begin
        seen_r   <= in_tlast ? 3'd0 : seen_nxt;
        stream_r <= acc_stream;
        cnt_r    <= acc_cnt;
      end else if (iss_load && cnt_r != '0) begin
        cnt_r <= cnt_r - sgf_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (iss_load) begin
      pads_r <= pads_nxt;
    end
    if (in_acc) begin
      win_r[0] <= sample;
      for (int k = 1; k < MAX_TAPS; k++) begin
        win_r[k] <= win_r[k - 1];
      end
      t_r   <= acc_first;
      fin_r <= in_tlast;
      err_r <= acc_err;
    end else if (iss_load && cnt_r != '0) begin
      t_r <= t_r + 3'd1;
    end
  end

  assign dn_ctl  = ctl_r;
  assign dn_pads = pads_r;

`include "savitzky_golay_fir_filter_core_macros.svh"

  `SGF_ASSERT_NEVER(a_cnt_cap, cnt_r > sgf_pkg::RES_CAP, "more results pending than one item may give")
  `SGF_ASSERT(a_err_last, (ctl_r.valid && ctl_r.status != sgf_pkg::STAT_OK) |-> ctl_r.last, "error result not marked last")
  `SGF_ASSERT(a_iss_hold, (ctl_r.valid && !dn_ready) |=> (ctl_r.valid && $stable(pads_r)), "issued window changed while stalled")

endmodule
